### src/fixed_block_free_list_allocator_top_macros.svh
// Assertion macros shared by the free list allocator modules.
// Included by the controller and the datapath; no other dependencies.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on the rising edge, ignored while reset is low
`define FSA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("fsa assertion failed");
// Check that a condition never holds outside reset
`define FSA_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("fsa forbidden condition seen");
`else
`define FSA_ASSERT(lbl, clk, rstn, prop)
`define FSA_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### src/fsa_pkg.sv
// Shared types and constants of the fixed block free list allocator.
// No dependencies; imported by every module of the block.
package fsa_pkg;

    // Command codes of the input transfer
    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_INIT  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic take_item;    // an input transfer is accepted this cycle
        logic load_result;  // finish the item and fill the output register
    } t_dp_cmd;

    localparam int CNT_W   = 9;
    localparam int BYTES_W = 13;
    localparam int IDX_W   = 8;
    localparam int OFS_W   = 20;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam int ALIGN_BYTES    = 8;
    localparam int LINK_BYTES     = 8;
    localparam int POOL_HDR_BYTES = 24;
    localparam int MAX_PAYLOAD    = 4096;

    localparam int RST_BLOCK_COUNT = 256;
    localparam int RST_BLOCK_BYTES = 8;

    // Register indexes, byte address is four times the index
    localparam logic REG_BLOCK_COUNT = 1'b0;
    localparam logic REG_BLOCK_BYTES = 1'b1;

endpackage

### src/fsa_cfg.sv
// APB-style configuration registers: block count and block payload size.
// Depends on fsa_pkg.
module fsa_cfg
    import fsa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready,
    output logic [CNT_W-1:0]     o_block_count,
    output logic [BYTES_W-1:0]   o_block_bytes
);

    logic [CNT_W-1:0]   r_block_count;
    logic [BYTES_W-1:0] r_block_bytes;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Write registers on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= CNT_W'(RST_BLOCK_COUNT);
            r_block_bytes <= BYTES_W'(RST_BLOCK_BYTES);
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_BLOCK_COUNT: r_block_count <= pwdata[CNT_W-1:0];
                REG_BLOCK_BYTES: r_block_bytes <= pwdata[BYTES_W-1:0];
                default:         r_block_count <= r_block_count;
            endcase
        end
    end

    // Return register contents, zero extended
    always_comb begin
        unique case (paddr[2])
            REG_BLOCK_COUNT: prdata = DATA_W'(r_block_count);
            REG_BLOCK_BYTES: prdata = DATA_W'(r_block_bytes);
            default:         prdata = '0;
        endcase
    end

    assign o_block_count = r_block_count;
    assign o_block_bytes = r_block_bytes;

endmodule

### src/fsa_ctrl.sv
// Controller: handshake on both channels and the two-state item sequence.
// Depends on fsa_pkg and the assertion macro header.
`include "fixed_block_free_list_allocator_top_macros.svh"
module fsa_ctrl
    import fsa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // Hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Advance on accepted input; finish once the output register is free
    always_comb begin
        n_state           = r_state;
        o_cmd.take_item   = 1'b0;
        o_cmd.load_result = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.take_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (o_cmd.load_result) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

    `FSA_ASSERT(a_take_enters_exec, i_clk, i_rst_n, o_cmd.take_item |=> r_state == S_EXEC)
    `FSA_ASSERT(a_load_sets_valid, i_clk, i_rst_n, o_cmd.load_result |=> r_out_valid)
    `FSA_ASSERT_NEVER(a_take_and_load, i_clk, i_rst_n, o_cmd.take_item && o_cmd.load_result)
    `FSA_ASSERT(a_exec_leaves, i_clk, i_rst_n,
        (r_state == S_EXEC && !r_out_valid) |=> r_state == S_IDLE)

endmodule

### src/fsa_dp.sv
// Datapath: free list head, link memory, fresh-block counter, free count,
// offset multiplier and output registers. Depends on fsa_pkg and the macros.
`include "fixed_block_free_list_allocator_top_macros.svh"
module fsa_dp
    import fsa_pkg::*;
#(
    parameter int MAX_BLOCKS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic [1:0]           i_command,
    input  logic [IDX_W-1:0]     i_block_index,
    input  logic [CNT_W-1:0]     i_block_count,
    input  logic [BYTES_W-1:0]   i_block_bytes,
    output logic                 o_granted,
    output logic [IDX_W-1:0]     o_granted_index,
    output logic [OFS_W-1:0]     o_block_offset,
    output logic [1:0]           o_status,
    output logic [CNT_W-1:0]     o_free_count
);

    localparam int IW      = $clog2(MAX_BLOCKS);
    localparam int CAP     = (MAX_BLOCKS < (2**CNT_W - 1)) ? MAX_BLOCKS : (2**CNT_W - 1);
    localparam int RST_CNT = (MAX_BLOCKS < RST_BLOCK_COUNT) ? MAX_BLOCKS : RST_BLOCK_COUNT;
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAP);
    localparam logic [CNT_W-1:0] RST_FREE = CNT_W'(RST_CNT);
    localparam int PROD_W = CNT_W + BYTES_W;

    // Link store: entry holds index+1 of the next freed block, 0 ends the list
    logic [CNT_W-1:0] r_link_mem [MAX_BLOCKS];
    logic [CNT_W-1:0] r_rd_link;

    logic [CNT_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_fresh, n_fresh;
    logic [CNT_W-1:0] r_free_total, n_free_total;
    logic             r_pop, n_pop;

    logic             r_res_granted;
    logic [CNT_W-1:0] r_res_gidx;
    t_status          r_res_status;
    logic             n_res_granted;
    logic [CNT_W-1:0] n_res_gidx;
    t_status          n_res_status;

    logic               r_out_granted;
    logic [IDX_W-1:0]   r_out_gidx;
    logic [OFS_W-1:0]   r_out_offset;
    t_status            r_out_status;
    logic [CNT_W-1:0]   r_out_free;

    t_cmd             cmd_code;
    logic [CNT_W-1:0] eff_n;
    logic [BYTES_W-1:0] pay_bytes;
    logic [BYTES_W:0]   pay_round;
    logic [BYTES_W-1:0] stride;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W:0]    ofs_sum;
    logic             have_list, have_fresh, idx_bad;
    logic             mem_we, mem_re;
    logic [IW-1:0]    rd_addr, wr_addr;

    // Clamp registers and form the block stride
    always_comb begin
        if (i_block_count == '0) begin
            eff_n = CNT_W'(1);
        end else if (i_block_count > CAP_CNT) begin
            eff_n = CAP_CNT;
        end else begin
            eff_n = i_block_count;
        end

        if (i_block_bytes == '0) begin
            pay_bytes = BYTES_W'(1);
        end else if (i_block_bytes > BYTES_W'(MAX_PAYLOAD)) begin
            pay_bytes = BYTES_W'(MAX_PAYLOAD);
        end else begin
            pay_bytes = i_block_bytes;
        end
        pay_round = (BYTES_W+1)'(((BYTES_W+1)'(pay_bytes) + (BYTES_W+1)'(ALIGN_BYTES - 1))
                    / ALIGN_BYTES * ALIGN_BYTES);
        stride    = BYTES_W'(pay_round + (BYTES_W+1)'(LINK_BYTES));
    end

    assign cmd_code   = t_cmd'(i_command);
    assign have_list  = (r_head != '0);
    assign have_fresh = (r_fresh < eff_n);
    assign idx_bad    = (CNT_W'(i_block_index) >= eff_n);
    assign rd_addr    = IW'(r_head - CNT_W'(1));
    assign wr_addr    = IW'(i_block_index);

    // Decide the command on the accepting cycle
    always_comb begin
        n_head        = r_head;
        n_fresh       = r_fresh;
        n_free_total  = r_free_total;
        n_pop         = r_pop;
        n_res_granted = r_res_granted;
        n_res_gidx    = r_res_gidx;
        n_res_status  = r_res_status;
        mem_we        = 1'b0;
        mem_re        = 1'b0;

        if (i_cmd.take_item) begin
            n_res_granted = 1'b0;
            n_res_gidx    = '0;
            n_res_status  = ST_OK;
            unique case (cmd_code)
                CMD_ALLOC: begin
                    if (have_list) begin
                        n_res_granted = 1'b1;
                        n_res_gidx    = r_head - CNT_W'(1);
                        mem_re        = 1'b1;
                        n_pop         = 1'b1;
                    end else if (have_fresh) begin
                        n_res_granted = 1'b1;
                        n_res_gidx    = r_fresh;
                        n_fresh       = r_fresh + CNT_W'(1);
                    end else begin
                        n_res_status  = ST_EMPTY;
                    end
                    if ((have_list || have_fresh) && r_free_total != '0) begin
                        n_free_total = r_free_total - CNT_W'(1);
                    end
                end
                CMD_FREE: begin
                    if (idx_bad) begin
                        n_res_status = ST_RANGE;
                    end else begin
                        mem_we = 1'b1;
                        n_head = CNT_W'(i_block_index) + CNT_W'(1);
                        if (r_free_total < eff_n) begin
                            n_free_total = r_free_total + CNT_W'(1);
                        end
                    end
                end
                CMD_INIT: begin
                    n_head       = '0;
                    n_fresh      = '0;
                    n_free_total = eff_n;
                end
                CMD_NOP: begin
                    n_head = r_head;
                end
                default: n_head = r_head;
            endcase
        end else if (i_cmd.load_result && r_pop) begin
            // Pop: the head's link has arrived from the store
            n_head = r_rd_link;
            n_pop  = 1'b0;
        end
    end

    // Hold list control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_fresh      <= '0;
            r_free_total <= RST_FREE;
            r_pop        <= 1'b0;
        end else begin
            r_head       <= n_head;
            r_fresh      <= n_fresh;
            r_free_total <= n_free_total;
            r_pop        <= n_pop;
        end
    end

    // Link store, one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_link_mem[wr_addr] <= r_head;
        end
        if (mem_re) begin
            r_rd_link <= r_link_mem[rd_addr];
        end
    end

    // Hold the decided result until it moves to the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_granted <= 1'b0;
            r_res_gidx    <= '0;
            r_res_status  <= ST_OK;
        end else begin
            r_res_granted <= n_res_granted;
            r_res_gidx    <= n_res_gidx;
            r_res_status  <= n_res_status;
        end
    end

    // Payload offset: header, block index times stride, link header
    assign prod    = PROD_W'(r_res_gidx) * PROD_W'(stride);
    assign ofs_sum = (PROD_W+1)'(prod) + (PROD_W+1)'(POOL_HDR_BYTES + LINK_BYTES);

    // Fill the output register when the item finishes
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_out_granted <= r_res_granted;
            r_out_gidx    <= r_res_gidx[IDX_W-1:0];
            r_out_offset  <= r_res_granted ? ofs_sum[OFS_W-1:0] : '0;
            r_out_status  <= r_res_status;
            r_out_free    <= r_free_total;
        end
    end

    assign o_granted       = r_out_granted;
    assign o_granted_index = r_out_gidx;
    assign o_block_offset  = r_out_offset;
    assign o_status        = r_out_status;
    assign o_free_count    = r_out_free;

    `FSA_ASSERT(a_pop_clears, i_clk, i_rst_n, (r_pop && i_cmd.load_result) |=> !r_pop)
    `FSA_ASSERT_NEVER(a_pop_on_take, i_clk, i_rst_n, r_pop && i_cmd.take_item)
    `FSA_ASSERT(a_free_sets_head, i_clk, i_rst_n,
        (i_cmd.take_item && cmd_code == CMD_FREE && !idx_bad) |=> r_head != '0)
    `FSA_ASSERT_NEVER(a_grant_status, i_clk, i_rst_n, r_res_granted && r_res_status != ST_OK)
    `FSA_ASSERT_NEVER(a_fresh_cap, i_clk, i_rst_n, r_fresh > CAP_CNT)

endmodule

### src/fixed_block_free_list_allocator_top.sv
// Fixed block free list allocator, top level.
// Input channel (i_valid/o_ready) carries a command and a block index:
// allocate, free or init pool. Output channel (o_valid/i_ready) carries one
// result per command: granted flag, block index, payload byte offset,
// status and the free block count after the command.
// Each item is decided in the idle state, which also starts the link store
// read; in the execute state the popped link moves into the list head and
// the output register is filled. A new command is taken only in the idle
// state, so not before the previous one has left the execute state.
// The output register holds a finished result, so the next command is
// accepted while that result waits; if the receiver stalls, the following
// item waits in the execute state until the output register is taken.
// Reset empties the free list, rewinds the fresh-block counter and sets the
// free count to the pool size; the link store is not cleared. Registers
// block_count (byte address 0) and block_bytes (byte address 4) are for the
// user to write via the APB-style port while idle; the block does not check.
// Depends on fsa_pkg, fsa_cfg, fsa_ctrl and fsa_dp.
module fixed_block_free_list_allocator_top
    import fsa_pkg::*;
#(
    parameter int MAX_BLOCKS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_command,
    input  logic [IDX_W-1:0]     i_block_index,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_granted,
    output logic [IDX_W-1:0]     o_granted_index,
    output logic [OFS_W-1:0]     o_block_offset,
    output logic [1:0]           o_status,
    output logic [CNT_W-1:0]     o_free_count,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready
);

    logic [CNT_W-1:0]   block_count;
    logic [BYTES_W-1:0] block_bytes;
    t_dp_cmd            dp_cmd;

    // Configuration registers
    fsa_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_block_count (block_count),
        .o_block_bytes (block_bytes)
    );

    // Sequencing and handshake
    fsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (dp_cmd)
    );

    // List state, link store and result path
    fsa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_command       (i_command),
        .i_block_index   (i_block_index),
        .i_block_count   (block_count),
        .i_block_bytes   (block_bytes),
        .o_granted       (o_granted),
        .o_granted_index (o_granted_index),
        .o_block_offset  (o_block_offset),
        .o_status        (o_status),
        .o_free_count    (o_free_count)
    );

endmodule

### dv/tb_fixed_block_free_list_allocator_top.sv
// Testbench of the fixed block free list allocator: directed and random command streams
// checked field by field against an in-bench model of the pool and its free list.
// Depends on fsa_pkg and the fixed_block_free_list_allocator_top RTL.
`timescale 1ns / 1ps

module tb_fixed_block_free_list_allocator_top
    import fsa_pkg::*;
();

    localparam int MAX_BLOCKS     = 256;
    localparam int ITEM_CYCLES    = 2;
    localparam int IDLE_PCT       = 22;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 115;

    typedef struct packed {
        logic             granted;
        logic [IDX_W-1:0] index;
        logic [OFS_W-1:0] offset;
        logic [1:0]       status;
        logic [CNT_W-1:0] free_cnt;
    } t_alloc_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_command = CMD_NOP;
    logic [IDX_W-1:0]   i_block_index = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_granted;
    logic [IDX_W-1:0]   o_granted_index;
    logic [OFS_W-1:0]   o_block_offset;
    logic [1:0]         o_status;
    logic [CNT_W-1:0]   o_free_count;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    // Pool model state and register copies
    logic [CNT_W-1:0]   cfg_count = CNT_W'(RST_BLOCK_COUNT);
    logic [BYTES_W-1:0] cfg_bytes = BYTES_W'(RST_BLOCK_BYTES);
    logic [CNT_W-1:0]   link_mem [MAX_BLOCKS];
    logic [CNT_W-1:0]   list_top = '0;
    logic [CNT_W-1:0]   fresh_next = '0;
    logic [CNT_W-1:0]   free_left = CNT_W'(RST_BLOCK_COUNT);

    t_alloc_result      pending_results [$];
    t_alloc_result      oldest;
    int unsigned        error_count = 0;
    int unsigned        stall_cycles = 0;
    logic               quiet = 1'b0;

    fixed_block_free_list_allocator_top #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_block_index  (i_block_index),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_granted      (o_granted),
        .o_granted_index(o_granted_index),
        .o_block_offset (o_block_offset),
        .o_status       (o_status),
        .o_free_count   (o_free_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Apply one command to the pool model and return the result it gives
    function automatic t_alloc_result predict_pool_step(input t_cmd cmd,
                                                        input logic [IDX_W-1:0] idx);
        int unsigned   n;
        int unsigned   payload;
        int unsigned   stride;
        logic          got;
        t_alloc_result r;
        n = (cfg_count == 0) ? 1 : (cfg_count > MAX_BLOCKS) ? MAX_BLOCKS : cfg_count;
        payload = (cfg_bytes == 0) ? 1 : (cfg_bytes > MAX_PAYLOAD) ? MAX_PAYLOAD : cfg_bytes;
        stride = LINK_BYTES + ((payload - 1) / ALIGN_BYTES + 1) * ALIGN_BYTES;
        r = '0;
        got = 1'b0;
        case (cmd)
            CMD_ALLOC: begin
                // pop a freed block first, else hand out the next fresh one
                if (list_top != 0) begin
                    r.index = IDX_W'(list_top - 1);
                    list_top = link_mem[list_top - 1];
                    got = 1'b1;
                end else if (fresh_next < n) begin
                    r.index = IDX_W'(fresh_next);
                    fresh_next = fresh_next + 1'b1;
                    got = 1'b1;
                end
                if (got) begin
                    r.granted = 1'b1;
                    if (free_left > 0) free_left = free_left - 1'b1;
                    r.offset = OFS_W'(POOL_HDR_BYTES + r.index * stride + LINK_BYTES);
                end else begin
                    r.status = ST_EMPTY;
                end
            end
            CMD_FREE: begin
                if (idx >= n) begin
                    r.status = ST_RANGE;
                end else begin
                    link_mem[idx] = list_top;
                    list_top = CNT_W'(idx) + 1'b1;
                    if (free_left < n) free_left = free_left + 1'b1;
                end
            end
            CMD_INIT: begin
                list_top = '0;
                fresh_next = '0;
                free_left = CNT_W'(n);
            end
            default: begin
            end
        endcase
        r.free_cnt = free_left;
        return r;
    endfunction

    // Present one command, hold it until the transfer, then record the expected result
    task automatic send_cmd(input t_cmd cmd, input logic [IDX_W-1:0] idx,
                            output t_alloc_result res);
        if (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_block_index <= idx;
        do @(posedge i_clk); while (!o_ready);
        res = predict_pool_step(cmd, idx);
        pending_results.push_back(res);
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic wait_results_done();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // One APB transfer: setup cycle, then access until pready
    task automatic apb_transfer(input logic wr, input logic sel,
                                input logic [DATA_W-1:0] wdata);
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'(4 * int'(sel));
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // Write both registers and read each back
    task automatic cfg_apply(input logic [DATA_W-1:0] count_val,
                             input logic [DATA_W-1:0] bytes_val);
        logic              sel;
        logic [DATA_W-1:0] stored;
        psel <= 1'b1;
        for (int k = 0; k < 2; k++) begin
            sel = (k == 0) ? REG_BLOCK_COUNT : REG_BLOCK_BYTES;
            apb_transfer(1'b1, sel, (k == 0) ? count_val : bytes_val);
            if (sel == REG_BLOCK_COUNT) begin
                cfg_count = count_val[CNT_W-1:0];
                stored = DATA_W'(cfg_count);
            end else begin
                cfg_bytes = bytes_val[BYTES_W-1:0];
                stored = DATA_W'(cfg_bytes);
            end
            apb_transfer(1'b0, sel, '0);
            if (prdata !== stored) begin
                $error("prdata: expected %0d, got %0d", stored, prdata);
                error_count++;
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Fresh blocks leave in ascending order after reset; index ignored off free
    task automatic test_fresh_order();
        t_alloc_result res;
        send_cmd(CMD_ALLOC, '0, res);
        send_cmd(CMD_ALLOC, '1, res);
        send_cmd(CMD_NOP, '1, res);
    endtask

    // Freed blocks are reused last in first out, double frees are granted twice
    task automatic test_lifo_reuse();
        t_alloc_result res;
        send_cmd(CMD_FREE, IDX_W'(MAX_BLOCKS - 1), res);
        send_cmd(CMD_ALLOC, '0, res);
        send_cmd(CMD_FREE, '0, res);
        send_cmd(CMD_FREE, '0, res);
        send_cmd(CMD_ALLOC, '0, res);
        send_cmd(CMD_ALLOC, '0, res);
    endtask

    // Out of range registers clamp; new values act before init, free count after
    task automatic test_register_clamps();
        t_alloc_result res;
        wait_results_done();
        cfg_apply(32'hFFFF_FE00, 32'hFFFF_FFFF);
        send_cmd(CMD_FREE, IDX_W'(1), res);
        send_cmd(CMD_FREE, '0, res);
        send_cmd(CMD_INIT, '1, res);
        send_cmd(CMD_ALLOC, '0, res);
        send_cmd(CMD_ALLOC, '0, res);
        send_cmd(CMD_FREE, '0, res);
        send_cmd(CMD_FREE, '0, res);
    endtask

    // Free count holds at zero and at the pool size; largest offset
    task automatic test_count_saturation();
        t_alloc_result res;
        wait_results_done();
        cfg_apply(32'd4, 32'd1);
        send_cmd(CMD_INIT, '0, res);
        repeat (4) send_cmd(CMD_ALLOC, '0, res);
        wait_results_done();
        cfg_apply(32'd511, 32'(MAX_PAYLOAD));
        send_cmd(CMD_ALLOC, '0, res);
        send_cmd(CMD_INIT, '0, res);
        send_cmd(CMD_FREE, IDX_W'(MAX_BLOCKS - 1), res);
        send_cmd(CMD_ALLOC, '0, res);
    endtask

    // Random traffic over several pool settings; frees mostly return held blocks
    task automatic test_random_traffic();
        t_alloc_result     res;
        logic [DATA_W-1:0] count_val;
        logic [DATA_W-1:0] bytes_val;
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  held [$];
        int unsigned       pick;
        t_cmd              cmd;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_results_done();
            case ($urandom_range(0, 5))
                0: count_val = $urandom_range(1, 4);
                1: count_val = $urandom_range(5, 32);
                2: count_val = $urandom_range(1, MAX_BLOCKS);
                3: count_val = MAX_BLOCKS;
                4: count_val = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_BLOCKS + 1, 511);
                default: count_val = $urandom_range(2, 8);
            endcase
            case ($urandom_range(0, 4))
                0: bytes_val = 0;
                1: bytes_val = $urandom_range(1, 64);
                2: bytes_val = $urandom_range(1, MAX_PAYLOAD);
                3: bytes_val = MAX_PAYLOAD;
                default: bytes_val = $urandom_range(MAX_PAYLOAD + 1, 8191);
            endcase
            cfg_apply(count_val, bytes_val);
            // one phase runs with no idling on either side
            quiet = (ph == 3);
            held.delete();
            if ($urandom_range(0, 3) != 0) send_cmd(CMD_INIT, IDX_W'($urandom), res);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                idx = IDX_W'($urandom);
                if (pick < 50) begin
                    cmd = CMD_ALLOC;
                end else if (pick < 88) begin
                    cmd = CMD_FREE;
                    if (held.size() != 0 && $urandom_range(0, 3) != 0) begin
                        pick = $urandom_range(0, held.size() - 1);
                        idx = held[pick];
                        held.delete(pick);
                    end
                end else if (pick < 92) begin
                    cmd = CMD_INIT;
                end else begin
                    cmd = CMD_NOP;
                end
                send_cmd(cmd, idx, res);
                if (cmd == CMD_INIT) held.delete();
                else if (res.granted) held.push_back(res.index);
            end
        end
        quiet = 1'b0;
    endtask

    // Check each result transfer against the oldest expectation, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no expected result waiting");
                error_count++;
            end else begin
                oldest = pending_results.pop_front();
                if (o_granted !== oldest.granted) begin
                    $error("granted: expected %0d, got %0d", oldest.granted, o_granted);
                    error_count++;
                end
                if (o_granted_index !== oldest.index) begin
                    $error("granted_index: expected %0d, got %0d", oldest.index,
                           o_granted_index);
                    error_count++;
                end
                if (o_block_offset !== oldest.offset) begin
                    $error("block_offset: expected %0d, got %0d", oldest.offset,
                           o_block_offset);
                    error_count++;
                end
                if (o_status !== oldest.status) begin
                    $error("status: expected %0d, got %0d", oldest.status, o_status);
                    error_count++;
                end
                if (o_free_count !== oldest.free_cnt) begin
                    $error("free_count: expected %0d, got %0d", oldest.free_cnt,
                           o_free_count);
                    error_count++;
                end
            end
        end
        i_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    // Stop a hung run: count cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_fixed_block_free_list_allocator_top failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_fresh_order();
        test_lifo_reuse();
        test_register_clamps();
        test_count_saturation();
        test_random_traffic();
        wait_results_done();
        repeat (4 * ITEM_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("tb_fixed_block_free_list_allocator_top passed");
        end else begin
            $display("tb_fixed_block_free_list_allocator_top failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/fsa_pkg.sv
src/fsa_cfg.sv
src/fsa_ctrl.sv
src/fsa_dp.sv
src/fixed_block_free_list_allocator_top.sv
dv/tb_fixed_block_free_list_allocator_top.sv
